FILE: design/ohm_pkg.sv
// Ordered hash map package: op codes, sequencer states, key hash and key compare.
// No dependencies; used by all design files.

package ohm_pkg;

   localparam int KEY_W  = 64;
   localparam int VAL_W  = 64;
   localparam int OP_W   = 3;
   localparam int HASH_W = 32;

   localparam logic [HASH_W-1:0] NAN_HASH = 32'h7ff8_0000;

   localparam logic [OP_W-1:0] OP_GET  = 3'd0;
   localparam logic [OP_W-1:0] OP_SET  = 3'd1;
   localparam logic [OP_W-1:0] OP_DEL  = 3'd2;
   localparam logic [OP_W-1:0] OP_CLR  = 3'd3;
   localparam logic [OP_W-1:0] OP_READ = 3'd4;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_HASH,
      ST_PWAIT,
      ST_PCHK,
      ST_KWAIT,
      ST_KCHK,
      ST_SH_CHK,
      ST_SH_WAIT,
      ST_SH_WR,
      ST_RB_CHK,
      ST_RB_WAIT,
      ST_RB_LOAD,
      ST_RD_WAIT,
      ST_RD_OUT
   } state_type;

   function automatic logic is_nan(input logic [KEY_W-1:0] k);
      return (k[62:52] == 11'h7ff) && (k[51:0] != '0);
   endfunction

   function automatic logic is_zero(input logic [KEY_W-1:0] k);
      return k[62:0] == '0;
   endfunction

   // SameValueZero-consistent fold of the key word
   function automatic logic [HASH_W-1:0] key_hash(input logic tag,
                                                 input logic [KEY_W-1:0] k);
      logic [KEY_W-1:0] w;
      w = k;
      if (tag && is_nan(k)) begin
         return NAN_HASH;
      end
      if (tag && is_zero(k)) begin
         w = '0;
      end
      return w[31:0] ^ w[63:32];
   endfunction

   function automatic logic keys_equal(input logic ta, input logic [KEY_W-1:0] a,
                                       input logic tb, input logic [KEY_W-1:0] b);
      if (ta != tb) begin
         return 1'b0;
      end
      if (ta) begin
         if (is_nan(a) && is_nan(b)) begin
            return 1'b1;
         end
         if (is_nan(a) || is_nan(b)) begin
            return 1'b0;
         end
         if (is_zero(a) && is_zero(b)) begin
            return 1'b1;
         end
      end
      return a == b;
   endfunction

endpackage

FILE: design/ohm_hash_mod.sv
// Hash unit: folds the key and masks it to a registered index slot.
// Depends on ohm_pkg; INDEX_DEPTH must be a power of two.

module ohm_hash_mod import ohm_pkg::*; #(
   parameter int INDEX_DEPTH = 128
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           go,
   input  logic                           tag,
   input  logic [KEY_W-1:0]               key,
   output logic                           done,
   output logic [$clog2(INDEX_DEPTH)-1:0] slot
);

   localparam int SW = $clog2(INDEX_DEPTH);

   logic [SW-1:0] slot_ff;
   logic          done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= go;
         if (go) begin
            slot_ff <= SW'(key_hash(tag, key));
         end
      end
   end

   assign done = done_ff;
   assign slot = slot_ff;

endmodule

FILE: design/ordered_hash_map.sv
// Ordered hash map top level: entry/index memories and the operation sequencer.
// Depends on ohm_pkg and ohm_hash_mod.
//
//  channel   handshake          payload
//  request   start & !busy      req_op, req_key_is_number, req_key, req_value, req_position
//  response  rsp_valid (1 cyc)  rsp_found, rsp_value_out, rsp_key_out,
//                               rsp_key_out_is_number, rsp_status, rsp_live_entries
//
// Get/set/delete: hash, then probe index slots in turn up to an empty slot or a matching
//   key; a live occupied slot also reads its entry key. Read-at reads the entry at
//   req_position; a bad op or position gets no lookup. Clear: index sweep. Delete hit:
//   shift later entries down, sweep the index, then hash and probe each remaining entry.
// After reset the whole index is swept with busy high.
// Results cannot be stalled; a new beat may be taken while a result shows.

module ordered_hash_map import ohm_pkg::*; #(
   parameter int ENTRY_DEPTH = 64,
   parameter int INDEX_DEPTH = 128
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [OP_W-1:0]                  req_op,
   input  logic                             req_key_is_number,
   input  logic [KEY_W-1:0]                 req_key,
   input  logic [VAL_W-1:0]                 req_value,
   input  logic [$clog2(ENTRY_DEPTH)-1:0]   req_position,
   output logic                             rsp_valid,
   output logic                             rsp_found,
   output logic [VAL_W-1:0]                 rsp_value_out,
   output logic [KEY_W-1:0]                 rsp_key_out,
   output logic                             rsp_key_out_is_number,
   output logic                             rsp_status,
   output logic [$clog2(ENTRY_DEPTH+1)-1:0] rsp_live_entries
);

   localparam int AW = $clog2(ENTRY_DEPTH);
   localparam int CW = $clog2(ENTRY_DEPTH + 1);
   localparam int SW = $clog2(INDEX_DEPTH);

   state_type state_ff, state_in;

   logic [OP_W-1:0]  op_ff;
   logic             tag_ff;
   logic [KEY_W-1:0] key_ff;
   logic [VAL_W-1:0] value_ff;
   logic [CW-1:0]    cnt_ff;
   logic [SW-1:0]    slot_ff, clr_ff;
   logic [AW-1:0]    ent_ff;
   logic [CW-1:0]    iter_ff;
   logic             rb_ff, boot_ff;

   logic             rsp_valid_ff, found_ff, ktag_ff, status_ff;
   logic [VAL_W-1:0] vout_ff;
   logic [KEY_W-1:0] kout_ff;

   logic [KEY_W:0]   key_mem [ENTRY_DEPTH];
   logic [VAL_W-1:0] val_mem [ENTRY_DEPTH];
   logic [CW-1:0]    idx_mem [INDEX_DEPTH];
   logic [KEY_W:0]   key_rd_ff;
   logic [VAL_W-1:0] val_rd_ff;
   logic [CW-1:0]    idx_rd_ff;

   logic             accept, pos_ok, full, e_empty, e_live, key_eq;
   logic             iter_more, sh_more, clr_last;
   logic [SW-1:0]    slot_next;

   logic             hm_go, hm_tag, hm_done;
   logic [KEY_W-1:0] hm_key;
   logic [SW-1:0]    hm_slot;

   logic             idx_we, key_we, val_we;
   logic [SW-1:0]    idx_wa;
   logic [CW-1:0]    idx_wd;
   logic [AW-1:0]    ent_wa;
   logic [KEY_W:0]   key_wd;
   logic [VAL_W-1:0] val_wd;
   logic             fin, fin_found, fin_ktag, fin_status;
   logic [VAL_W-1:0] fin_val;
   logic [KEY_W-1:0] fin_key;

   ohm_hash_mod #(.INDEX_DEPTH(INDEX_DEPTH)) u_hash (
      .clock (clock),
      .reset (reset),
      .go    (hm_go),
      .tag   (hm_tag),
      .key   (hm_key),
      .done  (hm_done),
      .slot  (hm_slot)
   );

   always_comb begin
      accept    = start && (state_ff == ST_IDLE);
      pos_ok    = (32'(req_position) < 32'(cnt_ff)) && (32'(req_position) < ENTRY_DEPTH);
      full      = (32'(cnt_ff) >= ENTRY_DEPTH) ||
                  ((32'(cnt_ff) + 32'd1) * 32'd4 > 32'(3 * INDEX_DEPTH));
      e_empty   = (idx_rd_ff == '0);
      e_live    = (idx_rd_ff - CW'(1)) < cnt_ff;
      key_eq    = keys_equal(key_rd_ff[KEY_W], key_rd_ff[KEY_W-1:0], tag_ff, key_ff);
      iter_more = iter_ff < cnt_ff;
      sh_more   = ({1'b0, iter_ff} + (CW+1)'(1)) < {1'b0, cnt_ff};
      clr_last  = (clr_ff == SW'(INDEX_DEPTH - 1));
      slot_next = (slot_ff == SW'(INDEX_DEPTH - 1)) ? '0 : slot_ff + SW'(1);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_op) inside
                  OP_GET, OP_SET, OP_DEL: state_in = ST_HASH;
                  OP_CLR:                 state_in = ST_CLEAR;
                  OP_READ:                state_in = pos_ok ? ST_RD_WAIT : ST_IDLE;
                  default:                state_in = ST_IDLE;
               endcase
            end
         end
         ST_CLEAR: begin
            if (clr_last) begin
               state_in = (!boot_ff && rb_ff) ? ST_RB_CHK : ST_IDLE;
            end
         end
         ST_HASH:    state_in = hm_done ? ST_PWAIT : ST_HASH;
         ST_PWAIT:   state_in = ST_PCHK;
         ST_PCHK: begin
            if (e_empty) begin
               state_in = rb_ff ? ST_RB_CHK : ST_IDLE;
            end else begin
               state_in = e_live ? ST_KWAIT : ST_PWAIT;
            end
         end
         ST_KWAIT:   state_in = ST_KCHK;
         ST_KCHK: begin
            if (!key_eq) begin
               state_in = ST_PWAIT;
            end else if (rb_ff) begin
               state_in = ST_RB_CHK;
            end else begin
               state_in = (op_ff == OP_DEL) ? ST_SH_CHK : ST_IDLE;
            end
         end
         ST_SH_CHK:  state_in = sh_more ? ST_SH_WAIT : ST_CLEAR;
         ST_SH_WAIT: state_in = ST_SH_WR;
         ST_SH_WR:   state_in = ST_SH_CHK;
         ST_RB_CHK:  state_in = iter_more ? ST_RB_WAIT : ST_IDLE;
         ST_RB_WAIT: state_in = ST_RB_LOAD;
         ST_RB_LOAD: state_in = ST_HASH;
         ST_RD_WAIT: state_in = ST_RD_OUT;
         ST_RD_OUT:  state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // outputs: memory writes, hash start, result
   always_comb begin
      busy       = (state_ff != ST_IDLE);
      hm_go      = 1'b0;
      hm_tag     = tag_ff;
      hm_key     = key_ff;
      idx_we     = 1'b0;
      idx_wa     = slot_ff;
      idx_wd     = CW'(iter_ff + CW'(1));
      key_we     = 1'b0;
      val_we     = 1'b0;
      ent_wa     = AW'(iter_ff);
      key_wd     = key_rd_ff;
      val_wd     = val_rd_ff;
      fin        = 1'b0;
      fin_found  = 1'b0;
      fin_val    = '0;
      fin_key    = '0;
      fin_ktag   = 1'b0;
      fin_status = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            hm_tag = req_key_is_number;
            hm_key = req_key;
            if (accept) begin
               case (req_op) inside
                  OP_GET, OP_SET, OP_DEL: hm_go = 1'b1;
                  OP_CLR:                 fin   = 1'b0;
                  OP_READ:                fin   = !pos_ok;
                  default:                fin   = 1'b1;
               endcase
            end
         end
         ST_CLEAR: begin
            idx_we = 1'b1;
            idx_wa = clr_ff;
            idx_wd = '0;
            fin    = clr_last && !boot_ff && !rb_ff;
         end
         ST_PCHK: begin
            if (e_empty) begin
               if (rb_ff) begin
                  idx_we = 1'b1;
               end else begin
                  fin = 1'b1;
                  if (op_ff == OP_SET) begin
                     if (full) begin
                        fin_status = 1'b1;
                     end else begin
                        idx_we = 1'b1;
                        idx_wd = CW'(cnt_ff + CW'(1));
                        key_we = 1'b1;
                        val_we = 1'b1;
                        ent_wa = AW'(cnt_ff);
                        key_wd = {tag_ff, key_ff};
                        val_wd = value_ff;
                     end
                  end
               end
            end
         end
         ST_KCHK: begin
            if (key_eq) begin
               if (rb_ff) begin
                  idx_we = 1'b1;
               end else if (op_ff == OP_GET) begin
                  fin       = 1'b1;
                  fin_found = 1'b1;
                  fin_val   = val_rd_ff;
               end else if (op_ff == OP_SET) begin
                  fin    = 1'b1;
                  val_we = 1'b1;
                  ent_wa = ent_ff;
                  val_wd = value_ff;
               end
            end
         end
         ST_SH_WR: begin
            key_we = 1'b1;
            val_we = 1'b1;
         end
         ST_RB_CHK: begin
            fin       = !iter_more;
            fin_found = 1'b1;
         end
         ST_RB_LOAD: begin
            hm_go  = 1'b1;
            hm_tag = key_rd_ff[KEY_W];
            hm_key = key_rd_ff[KEY_W-1:0];
         end
         ST_RD_OUT: begin
            fin       = 1'b1;
            fin_found = 1'b1;
            fin_val   = val_rd_ff;
            fin_key   = key_rd_ff[KEY_W-1:0];
            fin_ktag  = key_rd_ff[KEY_W];
         end
         default: begin
            fin = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[ent_wa] <= key_wd;
      end
      if (val_we) begin
         val_mem[ent_wa] <= val_wd;
      end
      if (idx_we) begin
         idx_mem[idx_wa] <= idx_wd;
      end
      key_rd_ff <= key_mem[ent_ff];
      val_rd_ff <= val_mem[ent_ff];
      idx_rd_ff <= idx_mem[slot_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         boot_ff      <= 1'b1;
         rb_ff        <= 1'b0;
         cnt_ff       <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= fin;
         if (fin) begin
            found_ff  <= fin_found;
            vout_ff   <= fin_val;
            kout_ff   <= fin_key;
            ktag_ff   <= fin_ktag;
            status_ff <= fin_status;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  op_ff    <= req_op;
                  tag_ff   <= req_key_is_number;
                  key_ff   <= req_key;
                  value_ff <= req_value;
                  rb_ff    <= 1'b0;
                  ent_ff   <= req_position;
                  if (req_op == OP_CLR) begin
                     cnt_ff <= '0;
                     clr_ff <= '0;
                  end
               end
            end
            ST_CLEAR: begin
               clr_ff <= clr_ff + SW'(1);
               if (clr_last) begin
                  boot_ff <= 1'b0;
                  iter_ff <= '0;
               end
            end
            ST_HASH: begin
               if (hm_done) begin
                  slot_ff <= hm_slot;
               end
            end
            ST_PCHK: begin
               if (e_empty) begin
                  if (rb_ff) begin
                     iter_ff <= iter_ff + CW'(1);
                  end else if (op_ff == OP_SET && !full) begin
                     cnt_ff <= cnt_ff + CW'(1);
                  end
               end else if (e_live) begin
                  ent_ff <= AW'(idx_rd_ff - CW'(1));
               end else begin
                  slot_ff <= slot_next;
               end
            end
            ST_KCHK: begin
               if (!key_eq) begin
                  slot_ff <= slot_next;
               end else if (rb_ff) begin
                  iter_ff <= iter_ff + CW'(1);
               end else begin
                  iter_ff <= CW'(ent_ff);
               end
            end
            ST_SH_CHK: begin
               if (sh_more) begin
                  ent_ff <= AW'(iter_ff + CW'(1));
               end else begin
                  cnt_ff <= cnt_ff - CW'(1);
                  clr_ff <= '0;
                  rb_ff  <= 1'b1;
               end
            end
            ST_SH_WR: begin
               iter_ff <= iter_ff + CW'(1);
            end
            ST_RB_CHK: begin
               if (iter_more) begin
                  ent_ff <= AW'(iter_ff);
               end
            end
            ST_RB_LOAD: begin
               tag_ff <= key_rd_ff[KEY_W];
               key_ff <= key_rd_ff[KEY_W-1:0];
            end
            default: begin
               rb_ff <= rb_ff;
            end
         endcase
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_found             = found_ff;
   assign rsp_value_out         = vout_ff;
   assign rsp_key_out           = kout_ff;
   assign rsp_key_out_is_number = ktag_ff;
   assign rsp_status            = status_ff;
   assign rsp_live_entries      = cnt_ff;

endmodule

FILE: design/ohm_checker.sv
// Port-level checks for ordered_hash_map, attached by bind.
// Depends on ohm_pkg.

module ohm_checker import ohm_pkg::*; #(
   parameter int ENTRY_DEPTH = 64,
   parameter int INDEX_DEPTH = 128
) (
   input logic                             clock,
   input logic                             reset,
   input logic                             start,
   input logic                             busy,
   input logic                             rsp_valid,
   input logic                             rsp_found,
   input logic                             rsp_key_out_is_number,
   input logic                             rsp_status,
   input logic [$clog2(ENTRY_DEPTH+1)-1:0] rsp_live_entries
);

   localparam int SW = $clog2(INDEX_DEPTH);

   a_status_no_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> !rsp_found)
      else $error("dropped insert beat reports a hit");

   a_tag_needs_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_key_out_is_number |-> rsp_found)
      else $error("key tag returned without a hit");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(rsp_live_entries) <= ENTRY_DEPTH && SW > 0)
      else $error("live entry count beyond capacity");

   a_rsp_has_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !$past(busy) |-> $past(start))
      else $error("result beat without an accepted request");

endmodule

bind ordered_hash_map ohm_checker #(
   .ENTRY_DEPTH(ENTRY_DEPTH),
   .INDEX_DEPTH(INDEX_DEPTH)
) u_ohm_checker (
   .clock                 (clock),
   .reset                 (reset),
   .start                 (start),
   .busy                  (busy),
   .rsp_valid             (rsp_valid),
   .rsp_found             (rsp_found),
   .rsp_key_out_is_number (rsp_key_out_is_number),
   .rsp_status            (rsp_status),
   .rsp_live_entries      (rsp_live_entries)
);

FILE: tb/ordered_hash_map_test.sv
// Self-checking testbench for ordered_hash_map: random and directed map operations,
// predicted by a behavioral map model. Depends on ohm_pkg and the ordered_hash_map RTL.
`timescale 1ns / 100ps

module ordered_hash_map_test;
   import ohm_pkg::*;

   localparam int NENT   = 64;
   localparam int NIDX   = 128;
   localparam int LIMIT  = 200000;
   localparam logic [OP_W-1:0] OP_BAD = 3'd5;

   typedef struct {
      logic [OP_W-1:0]  op;
      logic             num;
      logic [KEY_W-1:0] key;
      logic [VAL_W-1:0] val;
      logic [5:0]       pos;
   } map_cmd_t;

   typedef struct {
      logic             found;
      logic [VAL_W-1:0] vout;
      logic [KEY_W-1:0] kout;
      logic             knum;
      logic             status;
      logic [6:0]       live;
   } map_rsp_t;

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   logic [OP_W-1:0]  req_op = '0;
   logic             req_key_is_number = 0;
   logic [KEY_W-1:0] req_key = '0;
   logic [VAL_W-1:0] req_value = '0;
   logic [5:0]       req_position = '0;
   logic rsp_valid, rsp_found, rsp_key_out_is_number, rsp_status;
   logic [VAL_W-1:0] rsp_value_out;
   logic [KEY_W-1:0] rsp_key_out;
   logic [6:0]       rsp_live_entries;

   ordered_hash_map dut (.*);

   initial begin
      forever #6 clock = ~clock;
   end

   // behavioral map state
   logic             m_num  [NENT];
   logic [KEY_W-1:0] m_key  [NENT];
   logic [VAL_W-1:0] m_val  [NENT];
   int               m_count = 0;

   map_cmd_t pending_cmds[$];
   map_rsp_t expected_rsps[$];
   int errors = 0, beats_in = 0, beats_out = 0, idle_cycles = 0, dropped = 0;
   int gap = 0;
   bit driving_done = 0;

   function automatic logic same_key(logic ta, logic [KEY_W-1:0] a,
                                     logic tb, logic [KEY_W-1:0] b);
      logic na, nb;
      na = (a[62:52] == 11'h7ff) && (a[51:0] != 0);
      nb = (b[62:52] == 11'h7ff) && (b[51:0] != 0);
      if (ta != tb) return 0;
      if (ta) begin
         if (na || nb) return na && nb;
         if (a[62:0] == 0 && b[62:0] == 0) return 1;
      end
      return a == b;
   endfunction

   // order in the dense array is insertion order; index layout is invisible
   function automatic map_rsp_t apply_map_op(map_cmd_t c);
      map_rsp_t r;
      int hit;
      r = '{0, 0, 0, 0, 0, 0};
      hit = -1;
      for (int i = 0; i < m_count; i++)
         if (hit < 0 && same_key(m_num[i], m_key[i], c.num, c.key)) hit = i;
      case (c.op)
         OP_GET: if (hit >= 0) begin
            r.found = 1;
            r.vout = m_val[hit];
         end
         OP_SET: if (hit >= 0) m_val[hit] = c.val;
            else if (m_count >= NENT || 4 * (m_count + 1) > 3 * NIDX) r.status = 1;
            else begin
               m_num[m_count] = c.num;
               m_key[m_count] = c.key;
               m_val[m_count] = c.val;
               m_count++;
            end
         OP_DEL: if (hit >= 0) begin
            r.found = 1;
            for (int i = hit; i + 1 < m_count; i++) begin
               m_num[i] = m_num[i+1];
               m_key[i] = m_key[i+1];
               m_val[i] = m_val[i+1];
            end
            m_count--;
         end
         OP_CLR: m_count = 0;
         OP_READ: if (c.pos < m_count) begin
            r.found = 1;
            r.vout = m_val[c.pos];
            r.kout = m_key[c.pos];
            r.knum = m_num[c.pos];
         end
         default: ;
      endcase
      r.live = m_count[6:0];
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      errors++;
      $display("mismatch beat %0d %s: got %h want %h", beats_out, what, got, want);
   endtask

   // driver
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) begin
            beats_in++;
            expected_rsps.push_back(apply_map_op(pending_cmds.pop_front()));
            gap = $urandom_range(0, 6);
            if ($urandom_range(0, 3) == 0) gap = 0;
         end
         if (start && !busy) start <= 0;
         else if (!start && pending_cmds.size() > 0 && !(start && !busy)) begin
            if (gap > 0) gap--;
            else begin
               start <= 1;
               req_op <= pending_cmds[0].op;
               req_key_is_number <= pending_cmds[0].num;
               req_key <= pending_cmds[0].key;
               req_value <= pending_cmds[0].val;
               req_position <= pending_cmds[0].pos;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         map_rsp_t e;
         beats_out++;
         if (expected_rsps.size() == 0) begin
            errors++;
            $display("unexpected result beat %0d", beats_out);
         end else begin
            e = expected_rsps.pop_front();
            if (rsp_found !== e.found)
               report_mismatch("found", 64'(rsp_found), 64'(e.found));
            if (rsp_value_out !== e.vout) report_mismatch("value_out", rsp_value_out, e.vout);
            if (rsp_key_out !== e.kout) report_mismatch("key_out", rsp_key_out, e.kout);
            if (rsp_key_out_is_number !== e.knum)
               report_mismatch("key_out_is_number", 64'(rsp_key_out_is_number),
                               64'(e.knum));
            if (rsp_status !== e.status)
               report_mismatch("status", 64'(rsp_status), 64'(e.status));
            if (rsp_live_entries !== e.live)
               report_mismatch("live_entries", 64'(rsp_live_entries), 64'(e.live));
            if (e.status) dropped++;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= LIMIT) begin
         $display("timeout after %0d idle cycles", LIMIT);
         $display("ordered_hash_map_test NOT OK");
         $finish;
      end
   end

   logic [KEY_W-1:0] key_pool[16];

   function automatic map_cmd_t make_cmd(logic [OP_W-1:0] op, logic num,
                                         logic [KEY_W-1:0] key, logic [VAL_W-1:0] val,
                                         logic [5:0] pos);
      map_cmd_t c;
      c.op = op; c.num = num; c.key = key; c.val = val; c.pos = pos;
      return c;
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   initial begin
      int op_pick;
      logic [KEY_W-1:0] k;
      logic [OP_W-1:0] o;
      repeat (10) @(posedge clock);
      reset <= 0;
      // directed: zeros, NaNs, extremes, tag mismatch, every op
      pending_cmds.push_back(make_cmd(OP_READ, 0, 0, 0, 0));
      pending_cmds.push_back(make_cmd(OP_GET, 1, 0, 0, 0));
      pending_cmds.push_back(make_cmd(OP_SET, 1, 64'h0, 64'h1111, 0));
      pending_cmds.push_back(make_cmd(OP_GET, 1, 64'h8000_0000_0000_0000, 0, 0));
      pending_cmds.push_back(make_cmd(OP_GET, 0, 64'h8000_0000_0000_0000, 0, 0));
      pending_cmds.push_back(make_cmd(OP_SET, 1, 64'h7ff8_0000_0000_0000, '1, 0));
      pending_cmds.push_back(make_cmd(OP_GET, 1, 64'hfff0_0000_0000_0001, 0, 0));
      pending_cmds.push_back(make_cmd(OP_GET, 1, 64'h7ff0_0000_0000_0000, 0, 0));
      pending_cmds.push_back(make_cmd(OP_SET, 0, '1, 64'h5a5a, 0));
      pending_cmds.push_back(make_cmd(OP_SET, 0, 64'h7ff8_0000_0000_0000, 64'h2, 0));
      pending_cmds.push_back(make_cmd(OP_SET, 0, '1, '1, 0));
      pending_cmds.push_back(make_cmd(OP_READ, 0, 0, 0, 3));
      pending_cmds.push_back(make_cmd(OP_READ, 0, 0, 0, 63));
      pending_cmds.push_back(make_cmd(OP_DEL, 1, 64'hffff_ffff_ffff_ffff, 0, 0));
      pending_cmds.push_back(make_cmd(OP_DEL, 1, 64'h8000_0000_0000_0000, 0, 0));
      pending_cmds.push_back(make_cmd(OP_READ, 0, 0, 0, 0));
      pending_cmds.push_back(make_cmd(OP_READ, 0, 0, 0, 2));
      for (int i = 5; i < 8; i++)
         pending_cmds.push_back(make_cmd(OP_W'(OP_BAD + i - 5), 1, '1, '1, '1));
      pending_cmds.push_back(make_cmd(OP_CLR, 0, 0, 0, 0));
      pending_cmds.push_back(make_cmd(OP_GET, 0, '1, 0, 0));
      // random: keys mostly from a small pool so hits and collisions are common
      for (int i = 0; i < 16; i++) begin
         key_pool[i] = rand64();
         if (i < 4) key_pool[i][31:0] = key_pool[i][63:32] ^ 32'h5;
      end
      key_pool[4] = 64'h7ff0_0000_0000_0abc;
      key_pool[5] = 64'h8000_0000_0000_0000;
      for (int i = 0; i < 600; i++) begin
         op_pick = $urandom_range(0, 99);
         if (op_pick < 45) o = OP_SET;
         else if (op_pick < 68) o = OP_GET;
         else if (op_pick < 78) o = OP_DEL;
         else if (op_pick < 96) o = OP_READ;
         else if (op_pick < 98) o = OP_CLR;
         else o = OP_W'(OP_BAD + $urandom_range(0, 2));
         k = ($urandom_range(0, 3) == 0) ? rand64() : key_pool[$urandom_range(0, 15)];
         pending_cmds.push_back(make_cmd(o, 1'($urandom_range(0, 1)), k, rand64(),
                                         6'($urandom_range(0, 63))));
      end
      // fill to capacity, then overflow
      pending_cmds.push_back(make_cmd(OP_CLR, 0, 0, 0, 0));
      for (int i = 0; i < 68; i++)
         pending_cmds.push_back(make_cmd(OP_SET, 0, rand64(), rand64(), 0));
      pending_cmds.push_back(make_cmd(OP_READ, 0, 0, 0, 63));
      pending_cmds.push_back(make_cmd(OP_DEL, 0, 0, 0, 0));
      wait (pending_cmds.size() == 0 && !start);
      wait (expected_rsps.size() == 0);
      repeat (300) @(posedge clock);
      $display("%0d operations sent, %0d results checked, %0d full-store drops seen",
               beats_in, beats_out, dropped);
      if (errors == 0 && expected_rsps.size() == 0) $display("ordered_hash_map_test OK");
      else $display("ordered_hash_map_test NOT OK");
      $finish;
   end

endmodule
